// ===== rtl/flrs_pkg.sv =====
// Shared types, constants and saturating fixed-point helpers for the lasso row solver.
package flrs_pkg;

  localparam int VW           = 32;   // value width, Q16.16
  localparam int FRAC         = 16;   // fraction bits
  localparam int JW           = 10;   // pass counter width
  localparam int PRED_MAX_DEF = 16;
  localparam int SAMP_MAX_DEF = 256;

  typedef logic signed [VW-1:0] val_t;

  typedef struct packed {
    logic ovf;
    val_t val;
  } sval_t;

  localparam val_t VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam val_t VMIN = {1'b1, {(VW-1){1'b0}}};
  // -0.5, the momentum factor of the first pass
  localparam val_t F_NEG_HALF = {{(VW-FRAC+1){1'b1}}, {(FRAC-1){1'b0}}};

  typedef enum logic [1:0] {
    KIND_PRED,
    KIND_RESP,
    KIND_WEIGHT,
    KIND_START
  } kind_t;

  typedef enum logic [2:0] {
    REG_PRED_USED,
    REG_SAMP_USED,
    REG_PENALTY,
    REG_STEP,
    REG_TOL,
    REG_ITER_LIMIT
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_START,
    S_DIVGO,
    S_DIV,
    S_MOM_MUL,
    S_MOM_W,
    S_MOM_WB,
    S_RES_ISS,
    S_RES_DRN,
    S_GRD_ISS,
    S_GRD_DRN,
    S_P_STEP,
    S_P_W1,
    S_P_U,
    S_P_W2,
    S_P_WL,
    S_P_W3,
    S_P_SOFT,
    S_P_WB,
    S_CHECK,
    S_EMIT
  } state_t;

  function automatic sval_t sat_add(val_t a, val_t b);
    logic signed [VW:0] s;
    sval_t r;
    s = {a[VW-1], a} + {b[VW-1], b};
    r.ovf = s[VW] ^ s[VW-1];
    r.val = r.ovf ? (s[VW] ? VMIN : VMAX) : s[VW-1:0];
    return r;
  endfunction

  function automatic sval_t sat_sub(val_t a, val_t b);
    logic signed [VW:0] s;
    sval_t r;
    s = {a[VW-1], a} - {b[VW-1], b};
    r.ovf = s[VW] ^ s[VW-1];
    r.val = r.ovf ? (s[VW] ? VMIN : VMAX) : s[VW-1:0];
    return r;
  endfunction

  // full product to Q16.16: floor shift, then saturate
  function automatic sval_t sat_prod(logic signed [2*VW-1:0] p);
    logic [2*VW-FRAC-1:VW-1] hi;
    sval_t r;
    hi = p[2*VW-1:VW-1+FRAC];
    r.ovf = !((&hi) || !(|hi));
    r.val = r.ovf ? (p[2*VW-1] ? VMIN : VMAX) : p[VW-1+FRAC:FRAC];
    return r;
  endfunction

  // a negative threshold compares as negative, so it never zeroes the value
  function automatic sval_t soft_thr(val_t z, val_t gam);
    logic signed [VW:0] ze;
    logic signed [VW:0] az;
    sval_t r;
    ze = {z[VW-1], z};
    az = (ze < 0) ? -ze : ze;
    r = '0;
    if ($signed({gam[VW-1], gam}) >= az) begin
      r = '0;
    end else if (ze > 0) begin
      r = sat_sub(z, gam);
    end else if (ze < 0) begin
      r = sat_add(z, gam);
    end
    return r;
  endfunction

endpackage

// ===== rtl/fista_lasso_row_solver_top.sv =====
// Weighted lasso solver (FISTA, soft threshold) for one response series, Q16.16 fixed point.
// Load items (predictor sample, response sample, weight/start value) are accepted only while no
// solve runs. A start item runs the passes (none when the tolerance is zero or the iteration
// limit is below 2) and then emits one item per coefficient. Each pass streams the residual and
// gradient sweeps, one predictor-memory read per cycle, through a single pipelined multiplier
// and drains it after each sweep; the momentum and update steps use the same multiplier, and the
// factor (j-2)/(j+1) comes from the divider (start, 26 divider steps, handoff; -0.5 directly on
// the first pass). The convergence check ends each pass. Coefficients are emitted one per cycle
// when the output side keeps up. No clearing pass.
module fista_lasso_row_solver_top #(
  parameter int MAX_PREDICTORS = flrs_pkg::PRED_MAX_DEF,
  parameter int MAX_SAMPLES    = flrs_pkg::SAMP_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic [3:0]         in_predictor_index,
  input  logic [7:0]         in_sample_index,
  input  logic signed [31:0] in_value,
  input  logic signed [31:0] in_start_coefficient,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_coefficient_index,
  output logic signed [31:0] out_coefficient,
  output logic               out_converged,
  output logic               out_saturated,
  output logic               out_last,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [30:0]        cfg_data
);

  localparam int PW = (MAX_PREDICTORS > 1) ? $clog2(MAX_PREDICTORS) : 1;
  localparam int SW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int AW = (MAX_PREDICTORS * MAX_SAMPLES > 1) ?
                      $clog2(MAX_PREDICTORS * MAX_SAMPLES) : 1;
  localparam int VW = flrs_pkg::VW;

  typedef struct packed {
    logic          valid;
    logic          first;
    logic          last;
    logic          grad;
    logic [PW-1:0] k;
    logic [SW-1:0] s;
  } tag_t;

  // configuration
  logic [4:0]  p_cfg_r;
  logic [8:0]  n_cfg_r;
  logic [30:0] lam_r, stp_r, tol_r;
  logic [9:0]  lim_r;

  flrs_pkg::state_t state_r, state_nxt;

  // storage
  flrs_pkg::val_t pmem   [MAX_PREDICTORS*MAX_SAMPLES];
  flrs_pkg::val_t rmem   [MAX_SAMPLES];
  flrs_pkg::val_t resmem [MAX_SAMPLES];
  flrs_pkg::val_t cur_r  [MAX_PREDICTORS];
  flrs_pkg::val_t prev_r [MAX_PREDICTORS];
  flrs_pkg::val_t mom_r  [MAX_PREDICTORS];
  flrs_pkg::val_t wgt_r  [MAX_PREDICTORS];
  flrs_pkg::val_t grad_r [MAX_PREDICTORS];
  logic [MAX_PREDICTORS-1:0] cur_vld_r;

  flrs_pkg::val_t pq_r, rq_r, xq_r, momq_r, y2_r, y3_r, acc_r, u_r, next_r;
  tag_t t1_r, t2_r, t3_r;

  logic [PW-1:0] ck_r, plast;
  logic [SW-1:0] cs_r, nlast;
  logic [flrs_pkg::JW-1:0] j_r;
  logic [VW-1:0] maxd_r;
  logic above_r, sat_r;

  logic in_acc, ck_last, cs_last, pipe_empty, iss, out_load, div_start, div_busy, sat_hit;
  logic [AW-1:0] iss_addr;
  flrs_pkg::val_t lam_v, stp_v, cur_rd, mul_a, mul_b, base, div_q, ad_v;
  flrs_pkg::sval_t mres, acc_sum, d1, vsum, usum, soft_v, dsub;
  logic [flrs_pkg::JW-1:0] j_inc;
  logic cont;

  assign in_acc = in_valid && in_ready;
  assign lam_v  = {1'b0, lam_r};
  assign stp_v  = {1'b0, stp_r};
  assign cur_rd = cur_vld_r[ck_r] ? cur_r[ck_r] : '0;

  always_comb begin
    if (p_cfg_r == 5'd0)                plast = '0;
    else if (p_cfg_r > MAX_PREDICTORS)  plast = PW'(MAX_PREDICTORS - 1);
    else                                plast = PW'(p_cfg_r - 5'd1);
    if (n_cfg_r == 9'd0)                nlast = '0;
    else if (n_cfg_r > MAX_SAMPLES)     nlast = SW'(MAX_SAMPLES - 1);
    else                                nlast = SW'(n_cfg_r - 9'd1);
  end

  assign ck_last    = (ck_r == plast);
  assign cs_last    = (cs_r == nlast);
  assign pipe_empty = !t1_r.valid && !t2_r.valid && !t3_r.valid;
  assign iss_addr   = AW'(ck_r * MAX_SAMPLES) + AW'(cs_r);
  assign j_inc      = j_r + flrs_pkg::JW'(1);
  assign cont       = (maxd_r > {1'b0, tol_r}) && (j_inc < lim_r);

  flrs_mul u_mul (
    .clk   (clk),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .res_o (mres)
  );

  flrs_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (div_start),
    .iter_i  (j_r),
    .busy_o  (div_busy),
    .quot_o  (div_q)
  );

  // arithmetic around the multiplier
  always_comb begin
    base    = t3_r.first ? (t3_r.grad ? '0 : y3_r) : acc_r;
    acc_sum = t3_r.grad ? flrs_pkg::sat_add(base, mres.val) : flrs_pkg::sat_sub(base, mres.val);
    d1      = flrs_pkg::sat_sub(cur_rd, prev_r[ck_r]);
    vsum    = flrs_pkg::sat_add(cur_rd, mres.val);
    usum    = flrs_pkg::sat_add(mom_r[ck_r], mres.val);
    soft_v  = flrs_pkg::soft_thr(u_r, mres.val);
    dsub    = flrs_pkg::sat_sub(next_r, mom_r[ck_r]);
    ad_v    = dsub.val[VW-1] ? (~dsub.val + 1'b1) : dsub.val;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      flrs_pkg::S_IDLE:
        if (in_acc && (flrs_pkg::kind_t'(in_kind) == flrs_pkg::KIND_START))
          state_nxt = flrs_pkg::S_START;
      flrs_pkg::S_START:
        state_nxt = ((tol_r != '0) && (lim_r > 10'd1)) ? flrs_pkg::S_DIVGO : flrs_pkg::S_EMIT;
      flrs_pkg::S_DIVGO:   state_nxt = flrs_pkg::S_DIV;
      flrs_pkg::S_DIV:     if (!div_busy) state_nxt = flrs_pkg::S_MOM_MUL;
      flrs_pkg::S_MOM_MUL: state_nxt = flrs_pkg::S_MOM_W;
      flrs_pkg::S_MOM_W:   state_nxt = flrs_pkg::S_MOM_WB;
      flrs_pkg::S_MOM_WB:  state_nxt = ck_last ? flrs_pkg::S_RES_ISS : flrs_pkg::S_MOM_MUL;
      flrs_pkg::S_RES_ISS: if (ck_last && cs_last) state_nxt = flrs_pkg::S_RES_DRN;
      flrs_pkg::S_RES_DRN: if (pipe_empty) state_nxt = flrs_pkg::S_GRD_ISS;
      flrs_pkg::S_GRD_ISS: if (ck_last && cs_last) state_nxt = flrs_pkg::S_GRD_DRN;
      flrs_pkg::S_GRD_DRN: if (pipe_empty) state_nxt = flrs_pkg::S_P_STEP;
      flrs_pkg::S_P_STEP:  state_nxt = flrs_pkg::S_P_W1;
      flrs_pkg::S_P_W1:    state_nxt = flrs_pkg::S_P_U;
      flrs_pkg::S_P_U:     state_nxt = flrs_pkg::S_P_W2;
      flrs_pkg::S_P_W2:    state_nxt = flrs_pkg::S_P_WL;
      flrs_pkg::S_P_WL:    state_nxt = flrs_pkg::S_P_W3;
      flrs_pkg::S_P_W3:    state_nxt = flrs_pkg::S_P_SOFT;
      flrs_pkg::S_P_SOFT:  state_nxt = flrs_pkg::S_P_WB;
      flrs_pkg::S_P_WB:    state_nxt = ck_last ? flrs_pkg::S_CHECK : flrs_pkg::S_P_STEP;
      flrs_pkg::S_CHECK:   state_nxt = cont ? flrs_pkg::S_DIVGO : flrs_pkg::S_EMIT;
      flrs_pkg::S_EMIT:    if (out_load && ck_last) state_nxt = flrs_pkg::S_IDLE;
      default:             state_nxt = flrs_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = 1'b0;
    iss       = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    mul_a     = t1_r.grad ? xq_r : momq_r;
    mul_b     = pq_r;
    sat_hit   = t3_r.valid && (mres.ovf || acc_sum.ovf);
    unique case (state_r)
      flrs_pkg::S_IDLE:    in_ready = 1'b1;
      flrs_pkg::S_DIVGO:   div_start = 1'b1;
      flrs_pkg::S_MOM_MUL: begin
        mul_a   = div_q;
        mul_b   = d1.val;
        sat_hit = d1.ovf;
      end
      flrs_pkg::S_MOM_WB:  sat_hit = mres.ovf || vsum.ovf;
      flrs_pkg::S_RES_ISS,
      flrs_pkg::S_GRD_ISS: iss = 1'b1;
      flrs_pkg::S_P_STEP: begin
        mul_a = stp_v;
        mul_b = grad_r[ck_r];
      end
      flrs_pkg::S_P_U: begin
        mul_a   = wgt_r[ck_r];
        mul_b   = lam_v;
        sat_hit = mres.ovf || usum.ovf;
      end
      flrs_pkg::S_P_WL: begin
        mul_a   = mres.val;
        mul_b   = stp_v;
        sat_hit = mres.ovf;
      end
      flrs_pkg::S_P_SOFT:  sat_hit = mres.ovf || soft_v.ovf;
      flrs_pkg::S_P_WB:    sat_hit = dsub.ovf;
      flrs_pkg::S_EMIT:    out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= flrs_pkg::S_IDLE;
      p_cfg_r   <= 5'd16;
      n_cfg_r   <= 9'd256;
      lam_r     <= '0;
      stp_r     <= 31'd65536;
      tol_r     <= 31'd66;
      lim_r     <= 10'd1000;
      cur_vld_r <= '0;
      t1_r      <= '0;
      t2_r      <= '0;
      t3_r      <= '0;
      ck_r      <= '0;
      cs_r      <= '0;
      j_r       <= flrs_pkg::JW'(1);
      maxd_r    <= '0;
      above_r   <= 1'b0;
      sat_r     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        unique case (flrs_pkg::reg_idx_t'(cfg_index))
          flrs_pkg::REG_PRED_USED:  p_cfg_r <= cfg_data[4:0];
          flrs_pkg::REG_SAMP_USED:  n_cfg_r <= cfg_data[8:0];
          flrs_pkg::REG_PENALTY:    lam_r   <= cfg_data;
          flrs_pkg::REG_STEP:       stp_r   <= cfg_data;
          flrs_pkg::REG_TOL:        tol_r   <= cfg_data;
          flrs_pkg::REG_ITER_LIMIT: lim_r   <= cfg_data[9:0];
          default: ;
        endcase
      end
      if (in_acc && (flrs_pkg::kind_t'(in_kind) == flrs_pkg::KIND_WEIGHT)
          && (in_predictor_index < MAX_PREDICTORS))
        cur_vld_r[PW'(in_predictor_index)] <= 1'b1;
      if (state_r == flrs_pkg::S_P_WB)
        cur_vld_r[ck_r] <= 1'b1;

      t1_r.valid <= iss;
      t1_r.grad  <= (state_r == flrs_pkg::S_GRD_ISS);
      t1_r.first <= (state_r == flrs_pkg::S_GRD_ISS) ? (cs_r == '0) : (ck_r == '0);
      t1_r.last  <= (state_r == flrs_pkg::S_GRD_ISS) ? cs_last : ck_last;
      t1_r.k     <= ck_r;
      t1_r.s     <= cs_r;
      t2_r       <= t1_r;
      t3_r       <= t2_r;

      if (sat_hit) sat_r <= 1'b1;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      unique case (state_r)
        flrs_pkg::S_START: begin
          ck_r    <= '0;
          cs_r    <= '0;
          j_r     <= flrs_pkg::JW'(1);
          above_r <= (tol_r != '0);
          sat_r   <= 1'b0;
        end
        flrs_pkg::S_MOM_WB,
        flrs_pkg::S_P_WB:
          ck_r <= ck_last ? '0 : ck_r + PW'(1);
        flrs_pkg::S_RES_ISS:
          if (ck_last) begin
            ck_r <= '0;
            cs_r <= cs_last ? '0 : cs_r + SW'(1);
          end else begin
            ck_r <= ck_r + PW'(1);
          end
        flrs_pkg::S_GRD_ISS:
          if (cs_last) begin
            cs_r <= '0;
            ck_r <= ck_last ? '0 : ck_r + PW'(1);
          end else begin
            cs_r <= cs_r + SW'(1);
          end
        flrs_pkg::S_GRD_DRN:
          maxd_r <= '0;
        flrs_pkg::S_CHECK: begin
          above_r <= (maxd_r > {1'b0, tol_r});
          j_r     <= j_inc;
        end
        flrs_pkg::S_EMIT:
          if (out_load) ck_r <= ck_last ? '0 : ck_r + PW'(1);
        default: ;
      endcase
      if ((state_r == flrs_pkg::S_P_WB) && (ad_v > maxd_r))
        maxd_r <= ad_v;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc && (flrs_pkg::kind_t'(in_kind) == flrs_pkg::KIND_WEIGHT)
        && (in_predictor_index < MAX_PREDICTORS)) begin
      wgt_r[PW'(in_predictor_index)] <= in_value;
      cur_r[PW'(in_predictor_index)] <= in_start_coefficient;
    end
    if (state_r == flrs_pkg::S_START) begin
      for (int i = 0; i < MAX_PREDICTORS; i++)
        prev_r[i] <= cur_vld_r[i] ? cur_r[i] : '0;
    end
    if (state_r == flrs_pkg::S_MOM_WB) mom_r[ck_r] <= vsum.val;
    if (state_r == flrs_pkg::S_P_U)    u_r <= usum.val;
    if (state_r == flrs_pkg::S_P_SOFT) next_r <= soft_v.val;
    if (state_r == flrs_pkg::S_P_WB) begin
      prev_r[ck_r] <= cur_rd;
      cur_r[ck_r]  <= next_r;
    end
    momq_r <= mom_r[ck_r];
    y2_r   <= rq_r;
    y3_r   <= y2_r;
    if (t3_r.valid) begin
      acc_r <= acc_sum.val;
      if (t3_r.last && t3_r.grad) grad_r[t3_r.k] <= acc_sum.val;
    end
    if (out_load) begin
      out_coefficient_index <= 4'(ck_r);
      out_coefficient       <= cur_rd;
      out_converged         <= !above_r;
      out_saturated         <= sat_r;
      out_last              <= ck_last;
    end
  end

  // predictor samples, row k at k*MAX_SAMPLES
  always_ff @(posedge clk) begin
    if (in_acc && (flrs_pkg::kind_t'(in_kind) == flrs_pkg::KIND_PRED)
        && (in_predictor_index < MAX_PREDICTORS) && (in_sample_index < MAX_SAMPLES))
      pmem[AW'(in_predictor_index * MAX_SAMPLES) + AW'(in_sample_index)] <= in_value;
    pq_r <= pmem[iss_addr];
  end

  always_ff @(posedge clk) begin
    if (in_acc && (flrs_pkg::kind_t'(in_kind) == flrs_pkg::KIND_RESP)
        && (in_sample_index < MAX_SAMPLES))
      rmem[SW'(in_sample_index)] <= in_value;
    rq_r <= rmem[cs_r];
  end

  // residual store; gradient sweep starts only after the residual sweep drains
  always_ff @(posedge clk) begin
    if (t3_r.valid && t3_r.last && !t3_r.grad)
      resmem[t3_r.s] <= acc_sum.val;
    xq_r <= resmem[cs_r];
  end

endmodule

// ===== rtl/flrs_mul.sv =====
// Two-stage Q16.16 multiplier: registered full product, then registered floor shift and saturation.
module flrs_mul (
  input  logic            clk,
  input  flrs_pkg::val_t  a_i,
  input  flrs_pkg::val_t  b_i,
  output flrs_pkg::sval_t res_o
);

  logic signed [2*flrs_pkg::VW-1:0] prod_r;
  flrs_pkg::sval_t                  res_r;

  always_ff @(posedge clk) begin
    prod_r <= a_i * b_i;
    res_r  <= flrs_pkg::sat_prod(prod_r);
  end

  assign res_o = res_r;

endmodule

// ===== rtl/flrs_div.sv =====
// Radix-2 restoring divider for the momentum factor ((j-2)<<16)/(j+1).
module flrs_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start_i,
  input  logic [flrs_pkg::JW-1:0]   iter_i,
  output logic                      busy_o,
  output flrs_pkg::val_t            quot_o
);

  localparam int NW = flrs_pkg::JW + flrs_pkg::FRAC;
  localparam int DW = flrs_pkg::JW + 1;
  localparam int RW = DW + 1;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] num_r;
  logic [DW-1:0] den_r;
  logic [RW-1:0] rem_r;
  logic [CW-1:0] cnt_r;
  logic          neg_r;
  logic [RW-1:0] rem_sh;
  logic          ge;
  logic [RW-1:0] rem_nxt;

  always_comb begin
    rem_sh  = {rem_r[RW-2:0], num_r[NW-1]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_nxt = ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      neg_r <= 1'b0;
    end else if (start_i) begin
      // first pass gives -0.5 directly
      neg_r <= (iter_i == flrs_pkg::JW'(1));
      cnt_r <= (iter_i == flrs_pkg::JW'(1)) ? '0 : CW'(NW);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      num_r <= {iter_i - flrs_pkg::JW'(2), {flrs_pkg::FRAC{1'b0}}};
      den_r <= {1'b0, iter_i} + DW'(1);
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      num_r <= {num_r[NW-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign busy_o = (cnt_r != '0);
  assign quot_o = neg_r ? flrs_pkg::F_NEG_HALF : {{(flrs_pkg::VW-NW){1'b0}}, num_r};

endmodule

// ===== tb/fista_lasso_row_solver_top_tb.sv =====
// Self-checking testbench for the FISTA lasso row solver: directed table, then random load/solve phases.
module fista_lasso_row_solver_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint Q_HI = 64'sh7FFFFFFF;
  localparam longint Q_LO = -64'sh80000000;
  localparam logic [2:0] REG_NONE = 3'd6;   // index past the register list
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 60;
  localparam int RAND_ITEMS = 210;
  localparam int CYCLE_LIMIT = 25_000_000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_kind = '0;
  logic [3:0]         in_predictor_index = '0;
  logic [7:0]         in_sample_index = '0;
  logic signed [31:0] in_value = '0;
  logic signed [31:0] in_start_coefficient = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [3:0]         out_coefficient_index;
  logic signed [31:0] out_coefficient;
  logic               out_converged;
  logic               out_saturated;
  logic               out_last;
  logic               cfg_wr_en = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [30:0]        cfg_data = '0;

  fista_lasso_row_solver_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_predictor_index(in_predictor_index), .in_sample_index(in_sample_index),
    .in_value(in_value), .in_start_coefficient(in_start_coefficient),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_coefficient_index(out_coefficient_index), .out_coefficient(out_coefficient),
    .out_converged(out_converged), .out_saturated(out_saturated), .out_last(out_last),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  typedef struct {
    logic [3:0]         idx;
    logic signed [31:0] coef;
    logic               conv;
    logic               sat;
    logic               last;
  } coef_res_t;

  typedef struct {
    bit                 is_cfg;
    logic [2:0]         ridx;
    logic [30:0]        rdata;
    logic [1:0]         kind;
    logic [3:0]         pi;
    logic [7:0]         si;
    logic signed [31:0] v;
    logic signed [31:0] sc;
    bit                 typed;
    logic signed [31:0] tc;
    bit                 tconv;
  } dir_row_t;

  coef_res_t coef_due[$];

  // solver model state
  longint zmat [16][256];
  longint yvec [256];
  longint wvec [16];
  longint b_cur [16];
  longint b_prev [16];
  longint v_mom [16];
  bit     sat_hit;
  int unsigned cfg_p, cfg_n, cfg_lim;
  longint cfg_lam, cfg_step, cfg_tol;

  int  errs = 0;
  int  items_sent = 0;
  int  cyc = 0;
  bit  no_gaps = 0;
  bit  hold_req = 0;

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("fista_lasso_row_solver_top verification failed");
      $finish;
    end
  end

  function automatic longint qsat(longint x);
    if (x > Q_HI) begin
      sat_hit = 1;
      return Q_HI;
    end
    if (x < Q_LO) begin
      sat_hit = 1;
      return Q_LO;
    end
    return x;
  endfunction

  function automatic longint qadd(longint a, longint b);
    return qsat(a + b);
  endfunction

  function automatic longint qsub(longint a, longint b);
    return qsat(a - b);
  endfunction

  // operands are 32-bit, so the exact product fits in 64 bits
  function automatic longint qmul(longint a, longint b);
    longint pr;
    pr = a * b;
    return qsat(pr >>> 16);
  endfunction

  function automatic longint shrink(longint z, longint gam);
    longint az;
    az = (z < 0) ? -z : z;
    if (gam >= az) return 0;
    if (z > 0) return qsub(z, gam);
    if (z < 0) return qadd(z, gam);
    return 0;
  endfunction

  function automatic void cfg_apply(logic [2:0] idx, logic [30:0] d);
    case (idx)
      flrs_pkg::REG_PRED_USED:  cfg_p = d[4:0];
      flrs_pkg::REG_SAMP_USED:  cfg_n = d[8:0];
      flrs_pkg::REG_PENALTY:    cfg_lam = longint'(d);
      flrs_pkg::REG_STEP:       cfg_step = longint'(d);
      flrs_pkg::REG_TOL:        cfg_tol = longint'(d);
      flrs_pkg::REG_ITER_LIMIT: cfg_lim = d[9:0];
      default: ;
    endcase
  endfunction

  function automatic void solve_coefs(bit typed, logic signed [31:0] tc, bit tconv);
    int unsigned p, n, j;
    longint f, maxd, acc, g, u, gam, d, c;
    longint resid [256];
    longint nxt [16];
    bit above;
    coef_res_t r;
    p = (cfg_p < 1) ? 1 : ((cfg_p > 16) ? 16 : cfg_p);
    n = (cfg_n < 1) ? 1 : ((cfg_n > 256) ? 256 : cfg_n);
    sat_hit = 0;
    for (int k = 0; k < p; k++) b_prev[k] = b_cur[k];
    j = 1;
    above = cfg_tol > 0;
    while (above && j < cfg_lim) begin
      f = qsat(((longint'(j) - 2) * 65536) / (longint'(j) + 1));
      maxd = 0;
      for (int k = 0; k < p; k++)
        v_mom[k] = qadd(b_cur[k], qmul(f, qsub(b_cur[k], b_prev[k])));
      for (int s = 0; s < n; s++) begin
        acc = yvec[s];
        for (int k = 0; k < p; k++) acc = qsub(acc, qmul(v_mom[k], zmat[k][s]));
        resid[s] = acc;
      end
      for (int k = 0; k < p; k++) begin
        g = 0;
        for (int s = 0; s < n; s++) g = qadd(g, qmul(resid[s], zmat[k][s]));
        u = qadd(v_mom[k], qmul(cfg_step, g));
        gam = qmul(qmul(wvec[k], cfg_lam), cfg_step);
        nxt[k] = shrink(u, gam);
        d = qsub(nxt[k], v_mom[k]);
        if (d < 0) d = -d;
        if (d > maxd) maxd = d;
      end
      for (int k = 0; k < p; k++) begin
        b_prev[k] = b_cur[k];
        b_cur[k] = nxt[k];
      end
      above = maxd > cfg_tol;
      j++;
    end
    for (int k = 0; k < p; k++) begin
      c = b_cur[k];
      r.idx = k[3:0];
      r.coef = typed ? tc : c[31:0];
      r.conv = typed ? tconv : !above;
      r.sat = typed ? 1'b0 : sat_hit;
      r.last = (k == p - 1);
      coef_due.insert(coef_due.size(), r);
    end
  endfunction

  function automatic void item_apply(logic [1:0] kind, logic [3:0] pi, logic [7:0] si,
                                     logic signed [31:0] v, logic signed [31:0] sc,
                                     bit typed, logic signed [31:0] tc, bit tconv);
    case (kind)
      flrs_pkg::KIND_PRED: zmat[pi][si] = longint'(v);
      flrs_pkg::KIND_RESP: yvec[si] = longint'(v);
      flrs_pkg::KIND_WEIGHT: begin
        wvec[pi] = longint'(v);
        b_cur[pi] = longint'(sc);
      end
      default: solve_coefs(typed, tc, tconv);
    endcase
  endfunction

  task automatic send_item(logic [1:0] kind, logic [3:0] pi, logic [7:0] si,
                           logic signed [31:0] v, logic signed [31:0] sc,
                           bit typed = 0, logic signed [31:0] tc = 0, bit tconv = 0);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_kind <= kind;
    in_predictor_index <= pi;
    in_sample_index <= si;
    in_value <= v;
    in_start_coefficient <= sc;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    item_apply(kind, pi, si, v, sc, typed, tc, tconv);
  endtask

  // wait for every result, then let any trailing work finish
  task automatic settle();
    @(negedge clk) in_valid <= 1'b0;
    while (coef_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [30:0] d);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(negedge clk) cfg_wr_en <= 1'b0;
    cfg_apply(idx, d);
  endtask

  function automatic logic signed [31:0] rnd_val();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return $signed($urandom_range(0, 32'h60000)) - 32'sh30000;
  endfunction

  // result side
  initial begin
    int stall;
    coef_res_t e;
    wait (rst_n);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 10);
      if (hold_req) begin
        stall = HOLD_CYCLES;
        hold_req = 0;
      end
      if (stall > 0) begin
        @(negedge clk) out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk) out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (coef_due.size() == 0) begin
        $error("unexpected item: index %0d coefficient %0d", out_coefficient_index,
               out_coefficient);
        errs++;
      end else begin
        e = coef_due.pop_front();
        if (out_coefficient_index !== e.idx) begin
          $error("coefficient_index: expected %0d, got %0d", e.idx, out_coefficient_index);
          errs++;
        end
        if (out_coefficient !== e.coef) begin
          $error("coefficient: expected %0d, got %0d", e.coef, out_coefficient);
          errs++;
        end
        if (out_converged !== e.conv) begin
          $error("converged: expected %0d, got %0d", e.conv, out_converged);
          errs++;
        end
        if (out_saturated !== e.sat) begin
          $error("saturated: expected %0d, got %0d", e.sat, out_saturated);
          errs++;
        end
        if (out_last !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, out_last);
          errs++;
        end
      end
    end
  end

  task automatic run_phase(int ph);
    int p, n, nz;
    bit warm;
    no_gaps = ($urandom_range(0, 3) == 0);
    if (ph != 1 && $urandom_range(0, 5) == 0) begin
      // solve with no pass: counts may sit anywhere, nothing is read from the sample stores
      cfg_write(flrs_pkg::REG_PRED_USED, $urandom_range(0, 31));
      cfg_write(flrs_pkg::REG_SAMP_USED, $urandom_range(0, 511));
      if ($urandom_range(0, 1)) cfg_write(flrs_pkg::REG_TOL, 0);
      else cfg_write(flrs_pkg::REG_ITER_LIMIT, $urandom_range(0, 1));
      repeat ($urandom_range(1, 4))
        send_item(flrs_pkg::KIND_WEIGHT, $urandom, $urandom, rnd_val(), $urandom);
      send_item(flrs_pkg::KIND_START, $urandom, $urandom, $urandom, $urandom);
      return;
    end
    p = (ph == 1) ? 4 : $urandom_range(1, 4);
    n = $urandom_range(1, 8);
    cfg_write(flrs_pkg::REG_PRED_USED, p);
    cfg_write(flrs_pkg::REG_SAMP_USED, n);
    case ($urandom_range(0, 3))
      0: cfg_write(flrs_pkg::REG_PENALTY, 0);
      1: cfg_write(flrs_pkg::REG_PENALTY, 31'h7FFFFFFF);
      default: cfg_write(flrs_pkg::REG_PENALTY, $urandom_range(0, 32'h30000));
    endcase
    case ($urandom_range(0, 5))
      0: cfg_write(flrs_pkg::REG_STEP, 0);
      1: cfg_write(flrs_pkg::REG_STEP, 31'h7FFFFFFF);
      default: cfg_write(flrs_pkg::REG_STEP, $urandom_range(32'h800, 32'h10000));
    endcase
    if ($urandom_range(0, 4) == 0) begin
      cfg_write(flrs_pkg::REG_TOL, 31'h7FFFFFFF);
      cfg_write(flrs_pkg::REG_ITER_LIMIT, 1023);
    end else begin
      cfg_write(flrs_pkg::REG_TOL, $urandom_range(1, 32'h2000));
      cfg_write(flrs_pkg::REG_ITER_LIMIT, $urandom_range(2, 20));
    end
    for (int k = 0; k < p; k++)
      for (int s = 0; s < n; s++)
        send_item(flrs_pkg::KIND_PRED, k, s, rnd_val(), $urandom);
    for (int s = 0; s < n; s++)
      send_item(flrs_pkg::KIND_RESP, $urandom, s, rnd_val(), $urandom);
    for (int k = 0; k < p; k++)
      send_item(flrs_pkg::KIND_WEIGHT, k, $urandom, rnd_val(), rnd_val());
    if (ph == 1) hold_req = 1;
    send_item(flrs_pkg::KIND_START, $urandom, $urandom, $urandom, $urandom);
    warm = (ph == 1) || $urandom_range(0, 1);
    if (warm) send_item(flrs_pkg::KIND_START, $urandom, $urandom, $urandom, $urandom);
    // loads queue up behind the solve; indices reach past the active set
    nz = (ph == 1) ? 8 : $urandom_range(0, 4);
    repeat (nz) send_item($urandom_range(0, 2), $urandom, $urandom, $urandom, $urandom);
  endtask

  dir_row_t dir_tab [0:31];

  initial begin
    int ph;
    dir_tab = '{
      '{1, flrs_pkg::REG_TOL,        31'd0,        0, 0, 0, 0, 0, 0, 0, 0},
      '{1, flrs_pkg::REG_PRED_USED,  31'd31,       0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, flrs_pkg::KIND_START, 4'd0, 8'd0, 0, 0, 1, 32'sd0, 1},
      '{1, flrs_pkg::REG_PRED_USED,  31'd0,        0, 0, 0, 0, 0, 0, 0, 0},
      '{1, flrs_pkg::REG_SAMP_USED,  31'd0,        0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, flrs_pkg::KIND_WEIGHT, 4'd0, 8'd0, 32'sh7FFFFFFF, 32'sh80000000,
        0, 0, 0},
      '{0, 0, 0, flrs_pkg::KIND_PRED, 4'd0, 8'd0, 32'sh80000000, 32'sh7FFFFFFF,
        0, 0, 0},
      '{0, 0, 0, flrs_pkg::KIND_RESP, 4'd15, 8'd0, 32'sh7FFFFFFF, 32'sh0, 0, 0, 0},
      '{1, flrs_pkg::REG_TOL,        31'h7FFFFFFF, 0, 0, 0, 0, 0, 0, 0, 0},
      '{1, flrs_pkg::REG_ITER_LIMIT, 31'd1,        0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, flrs_pkg::KIND_START, 4'd15, 8'd255, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1,
        32'sh80000000, 0},
      '{1, flrs_pkg::REG_ITER_LIMIT, 31'd0,        0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, flrs_pkg::KIND_START, 4'd0, 8'd0, 0, 0, 1, 32'sh80000000, 0},
      '{1, flrs_pkg::REG_PENALTY,    31'h7FFFFFFF, 0, 0, 0, 0, 0, 0, 0, 0},
      '{1, flrs_pkg::REG_STEP,       31'h7FFFFFFF, 0, 0, 0, 0, 0, 0, 0, 0},
      '{1, flrs_pkg::REG_ITER_LIMIT, 31'd3,        0, 0, 0, 0, 0, 0, 0, 0},
      '{1, flrs_pkg::REG_TOL,        31'd1,        0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, flrs_pkg::KIND_START, 4'd0, 8'd0, 0, 0, 0, 0, 0},
      '{0, 0, 0, flrs_pkg::KIND_WEIGHT, 4'd15, 8'd255, 32'sh12345, 32'sh7FFFFFFF,
        0, 0, 0},
      '{0, 0, 0, flrs_pkg::KIND_PRED, 4'd15, 8'd255, -32'sd1, 32'sh0, 0, 0, 0},
      '{0, 0, 0, flrs_pkg::KIND_RESP, 4'd0, 8'd255, 32'sh10000, 32'sh0, 0, 0, 0},
      // negative weight grows the coefficient instead of shrinking it
      '{0, 0, 0, flrs_pkg::KIND_WEIGHT, 4'd0, 8'd0, -32'sh10000, 32'sh30000, 0, 0, 0},
      '{0, 0, 0, flrs_pkg::KIND_PRED, 4'd0, 8'd0, 32'sh10000, 32'sh0, 0, 0, 0},
      '{0, 0, 0, flrs_pkg::KIND_RESP, 4'd0, 8'd0, 32'sh20000, 32'sh0, 0, 0, 0},
      '{1, flrs_pkg::REG_PENALTY,    31'h8000,     0, 0, 0, 0, 0, 0, 0, 0},
      '{1, flrs_pkg::REG_STEP,       31'h4000,     0, 0, 0, 0, 0, 0, 0, 0},
      '{1, flrs_pkg::REG_ITER_LIMIT, 31'd8,        0, 0, 0, 0, 0, 0, 0, 0},
      '{1, REG_NONE,                 31'h7FFFFFFF, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, flrs_pkg::KIND_START, 4'd7, 8'd9, 0, 0, 0, 0, 0},
      '{0, 0, 0, flrs_pkg::KIND_START, 4'd0, 8'd0, 0, 0, 0, 0, 0},   // warm start
      '{1, flrs_pkg::REG_ITER_LIMIT, 31'd1023,     0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, flrs_pkg::KIND_START, 4'd0, 8'd0, 0, 0, 0, 0, 0}
    };
    cfg_p = 16;
    cfg_n = 256;
    cfg_lam = 0;
    cfg_step = 65536;
    cfg_tol = 66;
    cfg_lim = 1000;
    for (int k = 0; k < 16; k++) begin
      b_cur[k] = 0;
      b_prev[k] = 0;
      v_mom[k] = 0;
      wvec[k] = 0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        settle();
        cfg_write(dir_tab[i].ridx, dir_tab[i].rdata);
      end else begin
        send_item(dir_tab[i].kind, dir_tab[i].pi, dir_tab[i].si, dir_tab[i].v,
                  dir_tab[i].sc, dir_tab[i].typed, dir_tab[i].tc, dir_tab[i].tconv);
      end
    end

    ph = 0;
    while (items_sent < RAND_ITEMS) begin
      settle();
      run_phase(ph);
      ph++;
    end
    settle();
    if (errs == 0) $display("fista_lasso_row_solver_top verification clean");
    else $display("fista_lasso_row_solver_top verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/flrs_pkg.sv
rtl/flrs_mul.sv
rtl/flrs_div.sv
rtl/fista_lasso_row_solver_top.sv
tb/fista_lasso_row_solver_top_tb.sv
